/* rtl/gbn_pkg.sv */
package gbn_pkg;

  localparam int SEQ_W          = 16;
  localparam int SLOT_FIELD_W   = 3;
  localparam int DEFAULT_WINDOW = 8;

  // Event codes
  localparam logic [1:0] OP_KICK    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_RX      = 2'd2;

  // Received frame kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;

  // Register index
  localparam logic [0:0] REG_FRAME_COUNT = 1'd0;

  typedef struct packed {
    logic [1:0]       operation;
    logic [1:0]       rx_kind;
    logic [SEQ_W-1:0] rx_seq;
  } in_item_t;

  typedef struct packed {
    logic                    send_valid;
    logic [SEQ_W-1:0]        seq;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    resend;
    logic                    last;
    logic                    done_res;
  } out_item_t;

endpackage

/* rtl/go_back_n_sender_window.sv */
// Go-Back-N sender window. Raise start while busy is low to hand in one event
// (kick, timeout or received frame); busy stays high until the cycle that
// carries the event's last result, and a new event may be accepted at the edge
// that ends that cycle. Results appear one per cycle on out_item, each marked
// by a one-cycle out_strobe, and must be taken on that cycle: there is no
// back-pressure. A cumulative ack that frees slots (up to WINDOW) first passes
// ST_CLEAR, one slot per cycle through the base counter; every event then
// passes ST_PREP, which sets the burst end, and ST_BURST, which gives one empty
// result or up to WINDOW frames; the burst counter emits one sequence number
// per cycle. The user must write the frame count register over the APB port
// at address 0 only while busy is low; the block itself does not enforce this.
module go_back_n_sender_window #(
  parameter int WINDOW = gbn_pkg::DEFAULT_WINDOW
) (
  input  logic                clk,
  input  logic                rst_n,
  // event channel
  input  logic                start,
  output logic                busy,
  input  gbn_pkg::in_item_t   in_item,
  // result channel
  output logic                out_strobe,
  output gbn_pkg::out_item_t  out_item,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SEQ_W = gbn_pkg::SEQ_W;
  localparam int NX_W  = SEQ_W + 1;
  localparam logic [1:0] FRAME_COUNT_ADDR = 2'(4 * gbn_pkg::REG_FRAME_COUNT);

  typedef enum logic [1:0] {ST_IDLE, ST_CLEAR, ST_PREP, ST_BURST} state_t;

  state_t            state_r;
  logic [SEQ_W-1:0]  total_r;
  logic [SEQ_W-1:0]  base_r;
  logic [SW-1:0]     base_slot_r;
  logic [NX_W-1:0]   next_r;
  logic [SW-1:0]     next_slot_r;
  logic [SEQ_W-1:0]  ack_r;
  logic [NX_W-1:0]   stop_r;
  logic              done_r;
  logic              occ_r [WINDOW];
  logic              out_strobe_r;
  gbn_pkg::out_item_t out_r;

  logic              cfg_wr;
  logic [NX_W-1:0]   next_m1;
  logic [SEQ_W-1:0]  ack_sat;
  logic [NX_W-1:0]   base_plus_w;
  logic [NX_W-1:0]   stop_nxt;
  logic [SW+2:0]     slot_ext;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(WINDOW - 1)) ? '0 : s + SW'(1);
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {16'b0, total_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_wr && paddr == FRAME_COUNT_ADDR) begin
      total_r <= pwdata[SEQ_W-1:0];
    end
  end

  // Ack saturation and burst end
  assign next_m1     = next_r - NX_W'(1);
  assign ack_sat     = ({1'b0, in_item.rx_seq} > next_m1) ? next_m1[SEQ_W-1:0]
                                                          : in_item.rx_seq;
  assign base_plus_w = {1'b0, base_r} + NX_W'(WINDOW);
  assign stop_nxt    = (base_plus_w > {1'b0, total_r}) ? {1'b0, total_r} : base_plus_w;
  assign slot_ext    = {3'b000, next_slot_r};

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= '0;
      base_slot_r  <= '0;
      next_r       <= '0;
      next_slot_r  <= '0;
      out_strobe_r <= 1'b0;
      for (int k = 0; k < WINDOW; k++) occ_r[k] <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_BURST);
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            if (in_item.operation == gbn_pkg::OP_TIMEOUT) begin
              // rewind to the base
              next_r      <= {1'b0, base_r};
              next_slot_r <= base_slot_r;
              state_r     <= ST_PREP;
            end else if (in_item.operation == gbn_pkg::OP_RX &&
                         in_item.rx_kind == gbn_pkg::KIND_ACK) begin
              if (in_item.rx_seq < base_r) begin
                next_r      <= {1'b0, base_r};
                next_slot_r <= base_slot_r;
                state_r     <= ST_PREP;
              end else if (next_r > {1'b0, base_r}) begin
                ack_r   <= ack_sat;
                state_r <= ST_CLEAR;
              end else begin
                state_r <= ST_PREP;
              end
            end else begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_CLEAR: begin
          // free one slot and advance the base
          occ_r[base_slot_r] <= 1'b0;
          base_slot_r        <= slot_inc(base_slot_r);
          base_r             <= base_r + SEQ_W'(1);
          if (base_r == ack_r) state_r <= ST_PREP;
        end
        ST_PREP: begin
          stop_r  <= stop_nxt;
          done_r  <= (base_r >= total_r);
          state_r <= ST_BURST;
        end
        ST_BURST: begin
          out_r.done_res <= done_r;
          if (next_r < stop_r) begin
            out_r.send_valid    <= 1'b1;
            out_r.seq           <= next_r[SEQ_W-1:0];
            out_r.slot          <= slot_ext[2:0];
            out_r.resend        <= occ_r[next_slot_r];
            out_r.last          <= (next_r + NX_W'(1) == stop_r);
            occ_r[next_slot_r]  <= 1'b1;
            next_r              <= next_r + NX_W'(1);
            next_slot_r         <= slot_inc(next_slot_r);
            if (next_r + NX_W'(1) == stop_r) state_r <= ST_IDLE;
          end else begin
            // nothing to send: one empty result
            out_r.send_valid <= 1'b0;
            out_r.seq        <= '0;
            out_r.slot       <= '0;
            out_r.resend     <= 1'b0;
            out_r.last       <= 1'b1;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |-> !busy)
    else $error("last result while still busy");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.send_valid |-> out_item.last)
    else $error("empty result not marked last");

  a_next_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (next_r >= {1'b0, base_r}) && (next_r <= base_plus_w))
    else $error("next sequence outside window");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted event did not raise busy");
`endif

endmodule

/* tb/sv/tb_go_back_n_sender_window.sv */
module tb_go_back_n_sender_window;

  localparam int WIN = gbn_pkg::DEFAULT_WINDOW;
  // codes the package leaves unnamed: spare event code, reserved frame kinds
  localparam logic [1:0] OP_SPARE     = 2'd3;
  localparam logic [1:0] KIND_RSVD_LO = 2'd2;
  localparam logic [1:0] KIND_RSVD_HI = 2'd3;
  localparam logic [1:0] FRAME_COUNT_ADDR = 2'(4 * gbn_pkg::REG_FRAME_COUNT);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  gbn_pkg::in_item_t  in_item = '0;
  logic        out_strobe;
  gbn_pkg::out_item_t out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // window state as the sender should hold it
  logic [15:0] win_base = '0;
  logic [16:0] next_seq = '0;
  logic        slot_taken [WIN];
  logic [15:0] frame_count_cfg = '0;

  gbn_pkg::out_item_t pending_sends[$];
  int sender_idle_pct = 0;
  int events_sent = 0;
  int results_seen = 0;
  int errors = 0;

  go_back_n_sender_window dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one event to the window and queue the frames it should send
  task automatic predict_event(gbn_pkg::in_item_t it);
    int base;
    int nxt;
    int ack;
    int stop;
    int cnt;
    logic done;
    gbn_pkg::out_item_t r;
    base = win_base;
    nxt = next_seq;
    if (it.operation == gbn_pkg::OP_TIMEOUT) begin
      nxt = base;
    end else if (it.operation == gbn_pkg::OP_RX && it.rx_kind == gbn_pkg::KIND_ACK) begin
      ack = it.rx_seq;
      if (ack < base) begin
        nxt = base;
      end else if (nxt > base) begin
        // saturate to the highest sent frame, free acked slots
        if (ack > nxt - 1) ack = nxt - 1;
        for (int j = base; j <= ack && j < base + WIN; j++) slot_taken[j % WIN] = 1'b0;
        base = (ack + 1) & 16'hFFFF;
      end
    end
    stop = base + WIN;
    if (stop > frame_count_cfg) stop = frame_count_cfg;
    done = (base >= frame_count_cfg);
    cnt = 0;
    for (int i = nxt; i < stop && cnt < WIN; i++) begin
      r.send_valid = 1'b1;
      r.seq = 16'(i);
      r.slot = 3'(i % WIN);
      r.resend = slot_taken[i % WIN];
      r.last = (i + 1 == stop);
      r.done_res = done;
      slot_taken[i % WIN] = 1'b1;
      pending_sends.push_back(r);
      cnt++;
    end
    if (nxt < stop) nxt = stop;
    if (cnt == 0) begin
      r = '0;
      r.last = 1'b1;
      r.done_res = done;
      pending_sends.push_back(r);
    end
    win_base = 16'(base);
    next_seq = 17'(nxt);
  endtask

  function automatic gbn_pkg::in_item_t make_event(logic [1:0] op, logic [1:0] kind,
                                                   logic [15:0] seq);
    gbn_pkg::in_item_t it;
    it.operation = op;
    it.rx_kind = kind;
    it.rx_seq = seq;
    return it;
  endfunction

  // Hand one event to the block, idling at random before raising start
  task automatic send_event(gbn_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_event(it);
    events_sent++;
  endtask

  // Drop start and hold until every queued frame has come out
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_sends.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  // Write the frame count, then read it back
  task automatic write_frame_count(logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FRAME_COUNT_ADDR;
    pwdata <= {16'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    frame_count_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[15:0] !== value) begin
      $display("%0t: frame count readback expected %0d actual %0d", $time, value,
               prdata[15:0]);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each strobed result with the oldest queued frame
  always @(posedge clk) begin : check_results
    gbn_pkg::out_item_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        results_seen++;
        if (pending_sends.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_item);
          errors++;
        end else begin
          want = pending_sends.pop_front();
          check_field("send_valid", want.send_valid, out_item.send_valid);
          check_field("seq", want.seq, out_item.seq);
          check_field("slot", want.slot, out_item.slot);
          check_field("resend", want.resend, out_item.resend);
          check_field("last", want.last, out_item.last);
          check_field("done_res", want.done_res, out_item.done_res);
        end
      end else if (out_strobe !== 1'b0) begin
        $display("%0t: out_strobe expected 0 or 1 actual %b", $time, out_strobe);
        errors++;
      end
    end
  end

  // Reset value of the frame count: everything is done, acks are ignored
  task automatic test_after_reset();
    sender_idle_pct = 17;
    send_event(make_event(gbn_pkg::OP_KICK, gbn_pkg::KIND_ACK, 16'h0));
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_ACK, 16'd5));
    send_event(make_event(OP_SPARE, KIND_RSVD_HI, 16'hFFFF));
    wait_idle();
  endtask

  // Walk a small transfer through every event kind and corner
  task automatic test_directed_window();
    write_frame_count(16'd20);
    send_event(make_event(gbn_pkg::OP_KICK, gbn_pkg::KIND_ACK, 16'h0));     // full window
    send_event(make_event(gbn_pkg::OP_KICK, gbn_pkg::KIND_ACK, 16'h0));     // empty burst
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_ACK, 16'd2));       // partial ack
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_ACK, 16'hFFFF));    // ack saturates
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_ACK, 16'd0));       // below base
    send_event(make_event(gbn_pkg::OP_TIMEOUT, gbn_pkg::KIND_ACK, 16'h0));  // go back
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_DATA, 16'hFFFF));
    send_event(make_event(gbn_pkg::OP_RX, KIND_RSVD_LO, 16'd12));
    send_event(make_event(gbn_pkg::OP_RX, KIND_RSVD_HI, 16'h0));
    send_event(make_event(OP_SPARE, gbn_pkg::KIND_ACK, 16'd15));
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_ACK, 16'd18));
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_ACK, 16'd19));      // last ack, done
    send_event(make_event(gbn_pkg::OP_RX, gbn_pkg::KIND_ACK, 16'd25));      // no frame sent
    send_event(make_event(gbn_pkg::OP_TIMEOUT, gbn_pkg::KIND_DATA, 16'h0));
    wait_idle();
    // shrink the transfer below the send pointer
    write_frame_count(16'd5);
    send_event(make_event(gbn_pkg::OP_KICK, gbn_pkg::KIND_ACK, 16'h0));
    wait_idle();
  endtask

  // Mostly well-formed traffic: kicks, timeouts and acks near the window
  task automatic test_random_traffic(logic [15:0] total, int count, int idle_pct);
    gbn_pkg::in_item_t it;
    int pick;
    int outstanding;
    write_frame_count(total);
    sender_idle_pct = idle_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      outstanding = next_seq - win_base;
      it.rx_kind = 2'($urandom_range(3));
      it.rx_seq = 16'($urandom);
      if (pick < 30) begin
        it.operation = gbn_pkg::OP_KICK;
      end else if (pick < 36) begin
        it.operation = OP_SPARE;
      end else if (pick < 50) begin
        it.operation = gbn_pkg::OP_TIMEOUT;
      end else if (pick < 80) begin
        it.operation = gbn_pkg::OP_RX;
        it.rx_kind = gbn_pkg::KIND_ACK;
        it.rx_seq = 16'(win_base + $urandom_range(outstanding + 1));
      end else if (pick < 86) begin
        it.operation = gbn_pkg::OP_RX;
        it.rx_kind = gbn_pkg::KIND_ACK;
        it.rx_seq = 16'(win_base - $urandom_range(1, 3));
      end else begin
        it.operation = 2'($urandom_range(3));
      end
      send_event(it);
    end
    wait_idle();
  endtask

  initial begin
    for (int s = 0; s < WIN; s++) slot_taken[s] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_directed_window();
    test_random_traffic(16'hFFFF, 50, 17);
    test_random_traffic(16'(win_base + 2), 15, 17);
    test_random_traffic(16'(win_base + 60), 45, 80);
    test_random_traffic(16'h0, 10, 0);
    test_random_traffic(16'(win_base + 300), 70, 0);

    // let any stray result show up
    repeat (2 * WIN + 4) @(posedge clk);
    $display("Ran %0d events (kicks, timeouts, acks, data and invalid frames) and checked %0d",
             events_sent, results_seen);
    $display("results over seven frame-count settings, including 0 and 65535.");
    if (errors == 0 && pending_sends.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* go_back_n_sender_window.f */
rtl/gbn_pkg.sv
rtl/go_back_n_sender_window.sv
tb/sv/tb_go_back_n_sender_window.sv
